>>> rtl/core/dcmap_pkg.sv
package dcmap_pkg;

	localparam int NUM_CHANNELS = 3;

	// Channel order is red, green, blue.
	typedef logic [14:0] chan_base_t [NUM_CHANNELS];
	typedef logic signed [15:0] chan_slope_t [NUM_CHANNELS];

	// Both curves are held as 255 * color in hundredths. The base is the start
	// color and the slope is the end color minus the start color.
	localparam chan_base_t  BLUE_BASE   = '{15'd2040, 15'd5100, 15'd20400};
	localparam chan_slope_t BLUE_SLOPE  = '{16'sd23460, 16'sd20400, 16'sd5100};
	localparam chan_base_t  WHITE_BASE  = '{15'd25500, 15'd25500, 15'd25500};
	localparam chan_slope_t WHITE_SLOPE = '{-16'sd3825, -16'sd22950, -16'sd24225};

	// Position scale: t = floor((a * 80 + 3 * 32768) / 3), saturated to 0 .. 65536.
	localparam int           POS_OFFSET   = 98304;
	localparam int           POS_SAT      = 196608;
	localparam logic [22:0]  RECIP_THREE  = 23'd5592406;
	localparam int           RECIP_THREE_SHIFT = 24;

	// Smoothstep weight is 3 * 65536 - 2 * s.
	localparam logic [17:0]  SMOOTH_THREE = 18'd196608;

	// Final scaling: floor(y / 100) for y below 25600.
	localparam logic [14:0]  RECIP_HUNDRED = 15'd20972;
	localparam logic [14:0]  CHAN_MAX_SUM  = 15'd25500;

endpackage

>>> rtl/core/diverging_colormap_pixel_core.sv
// Diverging blue-white-red colormap: one signed Q4.12 amplitude sample in,
// one 8-bit RGB pixel out.
//
// Input channel: in_valid / in_ready with amplitude. Output channel:
// out_valid / out_ready with red, green and blue. A beat is taken on a rising
// clock edge at which valid and ready are both high.
//
// The datapath is a six-stage pipeline: position scaling, divide by three
// with saturation and branch select, squaring, smoothstep product, color
// blend, and the final divide by 100 into the output register. While the
// receiver keeps out_ready high, one beat can be accepted in every cycle,
// so throughput is one pixel per clock.
//
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and a stalled receiver backs the pipeline up one stage at
// a time. in_ready drops only once all six stages hold data and out_ready is
// low; nothing is lost or repeated across a stall.
//
// Reset clears all stage valid bits; the data registers are not reset.
module diverging_colormap_pixel_core #(
	parameter int AMPLITUDE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [AMPLITUDE_WIDTH-1:0] amplitude,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic        [7:0]                 red,
	output logic        [7:0]                 green,
	output logic        [7:0]                 blue
);

	localparam int NW = AMPLITUDE_WIDTH + 19;
	localparam int NCH = dcmap_pkg::NUM_CHANNELS;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	logic [17:0] n_s1;
	logic        sat_lo_s1, sat_hi_s1;
	logic [16:0] s_s2, s_s3;
	logic        upper_s2, upper_s3, upper_s4;
	logic [32:0] sq_s3;
	logic [16:0] h_s4;
	logic [14:0] y_s5 [NCH];
	logic [7:0]  c_s6 [NCH];

	logic signed [NW-1:0] amp_x, num;
	logic [40:0] q_prod;
	logic [16:0] t_pos;
	logic [16:0] s_next;
	logic        upper_next;
	logic [17:0] weight;
	logic [50:0] h_prod;
	logic [14:0] y_next [NCH];
	logic [7:0]  c_next [NCH];

	assign en_s6 = !v_s6 || out_ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s6;
	assign red = c_s6[0];
	assign green = c_s6[1];
	assign blue = c_s6[2];

	// Stage 1: position numerator a * 80 + 98304 and its saturation.
	always_comb begin
		amp_x = NW'(amplitude);
		num = (amp_x <<< 6) + (amp_x <<< 4) + NW'(dcmap_pkg::POS_OFFSET);
	end

	// Stage 2: exact floor division by three through a reciprocal, which
	// holds for numerators below 2^23; then the branch split.
	always_comb begin
		q_prod = 41'(n_s1) * 41'(dcmap_pkg::RECIP_THREE);
		if (sat_lo_s1) begin
			t_pos = '0;
		end else if (sat_hi_s1) begin
			t_pos = 17'h10000;
		end else begin
			t_pos = {1'b0, q_prod[dcmap_pkg::RECIP_THREE_SHIFT +: 16]};
		end
		upper_next = t_pos[16] | t_pos[15];
		s_next = t_pos[16] ? 17'h10000 : {1'b0, t_pos[14:0], 1'b0};
	end

	// Stage 4: h = s * s * (3 - 2s) in Q0.16.
	always_comb begin
		weight = dcmap_pkg::SMOOTH_THREE - {s_s3, 1'b0};
		h_prod = 51'(sq_s3) * 51'(weight);
	end

	// Stage 5 blends the channel; stage 6 divides by 100 by reciprocal.
	always_comb begin
		logic signed [33:0] blend;
		logic signed [17:0] blend_hi;
		logic [29:0]        div_prod;
		for (int k = 0; k < NCH; k++) begin
			blend = (upper_s4 ? dcmap_pkg::WHITE_SLOPE[k] : dcmap_pkg::BLUE_SLOPE[k])
				* $signed({1'b0, h_s4});
			blend_hi = blend[33:16];
			y_next[k] = 15'(18'($signed({3'b000,
				(upper_s4 ? dcmap_pkg::WHITE_BASE[k] : dcmap_pkg::BLUE_BASE[k])}))
				+ blend_hi);
			div_prod = 30'(y_s5[k]) * 30'(dcmap_pkg::RECIP_HUNDRED);
			c_next[k] = div_prod[28:21];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			n_s1 <= num[17:0];
			sat_lo_s1 <= (num <= 0);
			sat_hi_s1 <= (num >= NW'(dcmap_pkg::POS_SAT));
		end
		if (en_s2) begin
			s_s2 <= s_next;
			upper_s2 <= upper_next;
		end
		if (en_s3) begin
			sq_s3 <= 33'(34'(s_s2) * 34'(s_s2));
			s_s3 <= s_s2;
			upper_s3 <= upper_s2;
		end
		if (en_s4) begin
			h_s4 <= h_prod[48:32];
			upper_s4 <= upper_s3;
		end
		if (en_s5) begin
			y_s5 <= y_next;
		end
		if (en_s6) begin
			c_s6 <= c_next;
		end
	end

	a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !out_ready) |-> !in_ready)
		else $error("input accepted while the pipeline is full and stalled");

	a_stage5_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && en_s6) |=> out_valid)
		else $error("beat in the blend stage was dropped");

	a_lower_branch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !upper_s2) |-> (s_s2 < 17'h10000))
		else $error("lower branch position out of range");

	a_smooth_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (h_s4 <= 17'h10000))
		else $error("smoothstep weight above one");

	a_blend_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (y_s5[0] <= dcmap_pkg::CHAN_MAX_SUM && y_s5[1] <= dcmap_pkg::CHAN_MAX_SUM
			&& y_s5[2] <= dcmap_pkg::CHAN_MAX_SUM))
		else $error("blended channel above full scale");

endmodule

>>> tb/sv/diverging_colormap_checker.sv
module diverging_colormap_checker #(
	parameter int AMP_W = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic signed [AMP_W-1:0] amplitude,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic        [7:0]       red,
	input  logic        [7:0]       green,
	input  logic        [7:0]       blue,
	output int                      mismatches,
	output int                      pixels_pending,
	output int                      pixels_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// Position is Q0.16 with 65536 as 1.0; the amplitude scale 1/0.6 is 80/3 in raw units.
	localparam longint POS_ONE    = 65536;
	localparam longint POS_HALF   = 32768;
	localparam longint AMP_GAIN   = 80;
	localparam longint AMP_BIAS   = 3 * POS_HALF;
	localparam longint CHAN_SCALE = 255;
	localparam longint COLOR_DEN  = 100 * POS_ONE;
	localparam int     MAX_PRINTS = 40;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	pixel_t pixel_q[$];

	function automatic pixel_t colormap_pixel(input logic signed [AMP_W-1:0] amp);
		longint     num;
		longint     pos;
		longint     s;
		longint     h;
		longint     mix;
		int         from_c[3];
		int         to_c[3];
		logic [7:0] chan[3];
		pixel_t     px;
		num = longint'(amp) * AMP_GAIN + AMP_BIAS;
		pos = (num <= 0) ? 0 : num / 3;
		if (pos > POS_ONE)
			pos = POS_ONE;
		// Colors are in hundredths: blue into white below the midpoint, white into red above.
		if (pos < POS_HALF) begin
			s = 2 * pos;
			from_c = '{8, 20, 80};
			to_c = '{100, 100, 100};
		end else begin
			s = 2 * (pos - POS_HALF);
			from_c = '{100, 100, 100};
			to_c = '{85, 10, 5};
		end
		h = (s * s * (3 * POS_ONE - 2 * s)) >>> 32;
		for (int k = 0; k < 3; k++) begin
			mix = longint'(from_c[k]) * POS_ONE + longint'(to_c[k] - from_c[k]) * h;
			if (mix < 0)
				mix = 0;
			mix = mix * CHAN_SCALE / COLOR_DEN;
			if (mix > 255)
				mix = 255;
			chan[k] = mix[7:0];
		end
		px.red = chan[0];
		px.green = chan[1];
		px.blue = chan[2];
		return px;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < MAX_PRINTS)
			$display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		pixels_pending = 0;
		pixels_checked = 0;
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				pixel_q.push_back(colormap_pixel(amplitude));
			if (out_valid && out_ready) begin
				if (pixel_q.size() == 0) begin
					report_mismatch("unexpected pixel beat", 1, 0);
				end else begin
					want = pixel_q.pop_front();
					if (red !== want.red)
						report_mismatch("red", red, want.red);
					if (green !== want.green)
						report_mismatch("green", green, want.green);
					if (blue !== want.blue)
						report_mismatch("blue", blue, want.blue);
				end
				pixels_checked <= pixels_checked + 1;
			end
			pixels_pending <= pixel_q.size();
		end
	end

endmodule

>>> tb/sv/tb_diverging_colormap_pixel_core.sv
module tb_diverging_colormap_pixel_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AMP_W          = 16;
	localparam int RANDOM_SAMPLES = 850;
	localparam int LONG_HOLD      = 80;
	localparam int DRAIN_CYCLES   = 20;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [AMP_W-1:0] amplitude;
	logic                    out_valid;
	logic                    out_ready;
	logic        [7:0]       red;
	logic        [7:0]       green;
	logic        [7:0]       blue;
	int                      mismatches;
	int                      pixels_pending;
	int                      pixels_checked;
	int                      holds_done = 0;
	int                      directed_sent = 0;
	int                      random_sent = 0;

	always #5 clk = ~clk;

	diverging_colormap_pixel_core #(
		.AMPLITUDE_WIDTH(AMP_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.amplitude(amplitude),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	diverging_colormap_checker #(
		.AMP_W(AMP_W)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.amplitude     (amplitude),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.mismatches    (mismatches),
		.pixels_pending(pixels_pending),
		.pixels_checked(pixels_checked)
	);

	// Mostly back-to-back, sometimes a short gap, rarely a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_sample(input logic [AMP_W-1:0] amp);
		in_valid <= 1'b1;
		amplitude <= amp;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_input(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			amplitude <= AMP_W'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		#5ms;
		$display("timeout with %0d pixels outstanding", pixels_pending);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: random stalls, calm stretches, and two long holds that back up the pipeline.
	initial begin
		int  gap;
		bit  calm_rx;
		calm_rx = 1'b0;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (holds_done < 2 && pixels_checked >= (holds_done + 1) * 300) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if ($urandom_range(0, 63) == 0)
				calm_rx = ~calm_rx;
			gap = calm_rx ? 0 : gap_len();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int corners[19];
		int pick;
		bit calm;
		corners = '{-32768, 32767, 0, -1, 1, -1229, -1228, -1230, 1228, 1229,
			1230, -615, 615, -307, 307, -4096, 4096, 21845, -21846};
		arst_n = 1'b0;
		in_valid = 1'b0;
		amplitude = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Saturation edges on both sides, the midpoint and its neighbors, bit patterns.
		foreach (corners[i]) begin
			send_sample(AMP_W'(corners[i]));
			directed_sent++;
		end
		wait_drained();

		calm = 1'b0;
		for (int n = 0; n < RANDOM_SAMPLES; n++) begin
			if (n % 64 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (n == RANDOM_SAMPLES / 2)
				wait_drained();
			if (!calm)
				idle_input(gap_len());
			// Most samples land inside the colored span; the rest cover the full range.
			if ($urandom_range(0, 4) < 3)
				pick = int'($urandom_range(0, 2600)) - 1300;
			else
				pick = int'($urandom);
			send_sample(AMP_W'(pick));
			random_sent++;
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d corner and %0d random samples, checked %0d pixels",
			directed_sent, random_sent, pixels_checked);
		$display("receiver held off for %0d long stretches; input paused to drain %s",
			holds_done, "after the corners and mid-run");
		if (pixels_pending != 0)
			$display("%0d expected pixels never arrived", pixels_pending);
		if (mismatches == 0 && pixels_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
